>>> hw/rtl/png_unf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// png_unf_pkg
// Shared types and constants of the PNG scanline unfilter for RGBA8 pixels.
// ----------------------------------------------------------------------------
package png_unf_pkg;

	// width and reset of the row width register
	localparam int                      ROW_WIDTH_W     = 11;
	localparam logic [ROW_WIDTH_W-1:0]  ROW_WIDTH_RESET = 11'd1024;

	// filter types of a scanline
	typedef enum logic [2:0] {
		FILT_NONE  = 3'd0,
		FILT_SUB   = 3'd1,
		FILT_UP    = 3'd2,
		FILT_AVG   = 3'd3,
		FILT_PAETH = 3'd4
	} filter_t;

	// one pixel, channel 0 red, 1 green, 2 blue, 3 alpha
	typedef logic [3:0][7:0] pix_t;

	// position flags of the pixel being taken
	typedef struct packed {
		logic first_row;
		logic row_end;
	} pos_flags_t;

endpackage : png_unf_pkg
`default_nettype wire

>>> hw/rtl/png_unf_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// png_unf_in_if
// Filtered pixel channel: valid/ready handshake with filter type and bytes.
// ----------------------------------------------------------------------------
interface png_unf_in_if;
	logic       valid;
	logic       ready;
	logic [2:0] filter_type;
	logic [7:0] raw_red;
	logic [7:0] raw_green;
	logic [7:0] raw_blue;
	logic [7:0] raw_alpha;
	logic       image_start;

	modport source (
		output valid, filter_type, raw_red, raw_green, raw_blue, raw_alpha, image_start,
		input  ready
	);
	modport sink (
		input  valid, filter_type, raw_red, raw_green, raw_blue, raw_alpha, image_start,
		output ready
	);
endinterface : png_unf_in_if
`default_nettype wire

>>> hw/rtl/png_unf_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// png_unf_out_if
// Reconstructed pixel channel: valid/ready handshake with bytes and row end.
// ----------------------------------------------------------------------------
interface png_unf_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_red;
	logic [7:0] out_green;
	logic [7:0] out_blue;
	logic [7:0] out_alpha;
	logic       row_end;

	modport source (
		output valid, out_red, out_green, out_blue, out_alpha, row_end,
		input  ready
	);
	modport sink (
		input  valid, out_red, out_green, out_blue, out_alpha, row_end,
		output ready
	);
endinterface : png_unf_out_if
`default_nettype wire

>>> hw/rtl/png_scanline_unfilter_rgba8.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// png_scanline_unfilter_rgba8
// PNG scanline filter reconstruction for 8-bit RGBA pixels.
// ----------------------------------------------------------------------------
// Takes one filtered pixel per clock and gives one reconstructed pixel per
// clock while pix_out is ready, via the input and result registers. The
// pixel rate is set by the loop through the left-neighbour register: the
// predictor and add of one pixel feed the next pixel through it.
// The row above is kept in a single-port-write, registered-read store of
// MAX_ROW_PIXELS entries; it needs no clearing after reset, since the first
// row of an image never reads it. row_width is written through cfg_we and
// cfg_wdata and must only change while no pixel is in flight; a pixel with
// image_start set begins a new image at column zero.
// ----------------------------------------------------------------------------
module png_scanline_unfilter_rgba8
	import png_unf_pkg::*;
#(
	parameter int MAX_ROW_PIXELS = 1024
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [ROW_WIDTH_W-1:0] cfg_wdata,
	png_unf_in_if.sink                  pix_in,
	png_unf_out_if.source               pix_out
);

	localparam int COL_W = (MAX_ROW_PIXELS > 1) ? $clog2(MAX_ROW_PIXELS) : 1;

	logic [ROW_WIDTH_W-1:0] row_width_q;
	logic                   in_take;
	logic                   s1_move;
	logic [COL_W-1:0]       col_cur;
	pos_flags_t             flags_cur;

	logic                   valid_s1;
	logic [2:0]             type_s1;
	pix_t                   raw_s1;
	logic [COL_W-1:0]       col_s1;
	pos_flags_t             flags_s1;

	pix_t                   up_rd;
	pix_t                   a_pix;
	pix_t                   b_pix;
	pix_t                   c_pix;
	pix_t                   result;
	pix_t                   left_q;
	pix_t                   up_left_q;

	logic                   out_valid_q;
	pix_t                   out_pix_q;
	logic                   out_row_end_q;

	// row width register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q <= ROW_WIDTH_RESET;
		end else if (cfg_we) begin
			row_width_q <= cfg_wdata;
		end
	end

	// handshake: stage one moves when the output register is free or drains
	assign s1_move      = valid_s1 && (!out_valid_q || pix_out.ready);
	assign pix_in.ready = !valid_s1 || s1_move;
	assign in_take      = pix_in.valid && pix_in.ready;

	// position of the incoming pixel
	png_unf_pos #(
		.MAX_ROW_PIXELS (MAX_ROW_PIXELS)
	) u_pos (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (in_take),
		.start     (pix_in.image_start),
		.row_width (row_width_q),
		.col       (col_cur),
		.flags     (flags_cur)
	);

	// row above, read on transfer and written as each result leaves stage one
	png_unf_row_mem #(
		.MAX_ROW_PIXELS (MAX_ROW_PIXELS)
	) u_row_mem (
		.clk   (clk),
		.re    (in_take),
		.raddr (col_cur),
		.we    (s1_move),
		.waddr (col_s1),
		.wdata (result),
		.rdata (up_rd)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pix_in.ready) begin
			valid_s1 <= pix_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			type_s1  <= pix_in.filter_type;
			raw_s1   <= {pix_in.raw_alpha, pix_in.raw_blue, pix_in.raw_green, pix_in.raw_red};
			col_s1   <= col_cur;
			flags_s1 <= flags_cur;
		end
	end

	// neighbours, zero outside the image
	assign a_pix = (col_s1 == '0) ? '0 : left_q;
	assign b_pix = flags_s1.first_row ? '0 : up_rd;
	assign c_pix = ((col_s1 == '0) || flags_s1.first_row) ? '0 : up_left_q;

	png_unf_predict u_predict (
		.filter_type (type_s1),
		.raw         (raw_s1),
		.left        (a_pix),
		.up          (b_pix),
		.up_left     (c_pix),
		.result      (result)
	);

	// left and upper-left neighbours for the next pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q    <= '0;
			up_left_q <= '0;
		end else if (s1_move) begin
			left_q    <= result;
			up_left_q <= b_pix;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_move) begin
			out_valid_q <= 1'b1;
		end else if (pix_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			out_pix_q     <= result;
			out_row_end_q <= flags_s1.row_end;
		end
	end

	assign pix_out.valid     = out_valid_q;
	assign pix_out.out_red   = out_pix_q[0];
	assign pix_out.out_green = out_pix_q[1];
	assign pix_out.out_blue  = out_pix_q[2];
	assign pix_out.out_alpha = out_pix_q[3];
	assign pix_out.row_end   = out_row_end_q;

endmodule : png_scanline_unfilter_rgba8
`default_nettype wire

>>> hw/rtl/png_unf_pos.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// png_unf_pos
// Column counter and first-row flag; decides the row end of each pixel.
// ----------------------------------------------------------------------------
module png_unf_pos
	import png_unf_pkg::*;
#(
	parameter int MAX_ROW_PIXELS = 1024
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   take,
	input  wire logic                   start,
	input  wire logic [ROW_WIDTH_W-1:0] row_width,
	output logic [((MAX_ROW_PIXELS > 1) ? $clog2(MAX_ROW_PIXELS) : 1)-1:0] col,
	output pos_flags_t                  flags
);

	localparam int COL_W = (MAX_ROW_PIXELS > 1) ? $clog2(MAX_ROW_PIXELS) : 1;
	localparam int CMP_W = (COL_W + 1 > ROW_WIDTH_W) ? COL_W + 1 : ROW_WIDTH_W;
	localparam logic [CMP_W-1:0] MAX_W = CMP_W'(MAX_ROW_PIXELS);

	logic [COL_W-1:0] col_q;
	logic             first_q;
	logic [COL_W:0]   col_inc;
	logic [CMP_W-1:0] wid_raw;
	logic [CMP_W-1:0] wid_eff;
	logic             row_end;

	// position of this pixel, cleared by an image start
	assign col         = start ? '0 : col_q;
	assign flags.first_row = start | first_q;

	// effective width clamped to one and to the store depth
	always_comb begin
		wid_raw = CMP_W'(row_width);
		if (wid_raw == '0) begin
			wid_eff = CMP_W'(1);
		end else if (wid_raw > MAX_W) begin
			wid_eff = MAX_W;
		end else begin
			wid_eff = wid_raw;
		end
	end

	assign col_inc       = {1'b0, col} + (COL_W+1)'(1);
	assign row_end       = CMP_W'(col_inc) >= wid_eff;
	assign flags.row_end = row_end;

	// advance on every taken pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			first_q <= 1'b1;
		end else if (take) begin
			col_q   <= row_end ? '0 : col_inc[COL_W-1:0];
			first_q <= row_end ? 1'b0 : flags.first_row;
		end
	end

endmodule : png_unf_pos
`default_nettype wire

>>> hw/rtl/png_unf_row_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// png_unf_row_mem
// Row store of the previous reconstructed scanline, one write and one
// registered read per cycle, with the same-cycle write forwarded to the read.
// ----------------------------------------------------------------------------
module png_unf_row_mem
	import png_unf_pkg::*;
#(
	parameter int MAX_ROW_PIXELS = 1024
) (
	input  wire logic clk,
	input  wire logic re,
	input  wire logic [((MAX_ROW_PIXELS > 1) ? $clog2(MAX_ROW_PIXELS) : 1)-1:0] raddr,
	input  wire logic we,
	input  wire logic [((MAX_ROW_PIXELS > 1) ? $clog2(MAX_ROW_PIXELS) : 1)-1:0] waddr,
	input  wire pix_t wdata,
	output pix_t      rdata
);

	pix_t mem [MAX_ROW_PIXELS];
	pix_t rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, holds while no read is issued
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= (we && (waddr == raddr)) ? wdata : mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule : png_unf_row_mem
`default_nettype wire

>>> hw/rtl/png_unf_predict.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// png_unf_predict
// Per-channel predictor (sub, up, average, paeth) and modulo-256 add.
// ----------------------------------------------------------------------------
module png_unf_predict
	import png_unf_pkg::*;
(
	input  wire logic [2:0] filter_type,
	input  wire pix_t       raw,
	input  wire pix_t       left,
	input  wire pix_t       up,
	input  wire pix_t       up_left,
	output pix_t            result
);

	// paeth predictor of one channel
	function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] c);
		logic signed [10:0] p;
		logic signed [10:0] da;
		logic signed [10:0] db;
		logic signed [10:0] dc;
		logic [7:0]         sel;
		p  = $signed({3'b000, a}) + $signed({3'b000, b}) - $signed({3'b000, c});
		da = p - $signed({3'b000, a});
		db = p - $signed({3'b000, b});
		dc = p - $signed({3'b000, c});
		if (da < 0) da = -da;
		if (db < 0) db = -db;
		if (dc < 0) dc = -dc;
		if (da <= db && da <= dc) begin
			sel = a;
		end else if (db <= dc) begin
			sel = b;
		end else begin
			sel = c;
		end
		return sel;
	endfunction

	pix_t       pred;
	logic [8:0] avg_sum [4];

	// prediction, channels are independent
	always_comb begin
		for (int ch = 0; ch < 4; ch++) begin
			avg_sum[ch] = {1'b0, left[ch]} + {1'b0, up[ch]};
			case (filter_t'(filter_type))
				FILT_SUB:   pred[ch] = left[ch];
				FILT_UP:    pred[ch] = up[ch];
				FILT_AVG:   pred[ch] = avg_sum[ch][8:1];
				FILT_PAETH: pred[ch] = paeth(left[ch], up[ch], up_left[ch]);
				default:    pred[ch] = 8'd0;
			endcase
			result[ch] = raw[ch] + pred[ch];
		end
	end

endmodule : png_unf_predict
`default_nettype wire

>>> hw/rtl/png_unf_check.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// png_unf_check
// Port-level checks of the unfilter: result hold, occupancy and readiness.
// ----------------------------------------------------------------------------
module png_unf_check (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [32:0] out_data
);

	logic [2:0] cnt_q;
	logic       in_xfer;
	logic       out_xfer;

	assign in_xfer  = in_valid && in_ready;
	assign out_xfer = out_valid && out_ready;

	// pixels transferred in and not yet out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + {2'b00, in_xfer} - {2'b00, out_xfer};
		end
	end

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// no result without a pixel behind it
	a_out_backed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> cnt_q != 3'd0)
		else $error("result without a transferred pixel");

	// at most the input stage and the result register are occupied
	a_occupancy: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'd2)
		else $error("more than two pixels in flight");

	// an empty result register never blocks the input
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with result register empty");

endmodule : png_unf_check

bind png_scanline_unfilter_rgba8 png_unf_check u_png_unf_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (pix_in.valid),
	.in_ready  (pix_in.ready),
	.out_valid (pix_out.valid),
	.out_ready (pix_out.ready),
	.out_data  ({pix_out.row_end, pix_out.out_alpha, pix_out.out_blue,
		pix_out.out_green, pix_out.out_red})
);
`default_nettype wire

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the RGBA8 PNG scanline unfilter. A predictor tracks
// the row store, neighbours and position as pixels are taken on the input
// channel, and each pixel leaving the output channel is compared with the
// oldest prediction. Both channels idle at random; row width is changed
// between phases while the block is empty.
// ----------------------------------------------------------------------------
module tb_top;
	import png_unf_pkg::*;

	localparam int STORE_DEPTH   = 1024;
	localparam int RANDOM_PIXELS = 1050;
	localparam int DRAIN_CYCLES  = 8;

	// filter codes with no name in the package, passed through as none
	localparam logic [2:0] FILT_SPARE5 = 3'd5;
	localparam logic [2:0] FILT_SPARE6 = 3'd6;
	localparam logic [2:0] FILT_SPARE7 = 3'd7;

	typedef struct packed {
		pix_t px;
		logic row_end;
	} out_pixel_t;

	// predictor of reconstructed pixels and queue of pixels still due
	class unfilter_predictor;
		pix_t                   row_store [STORE_DEPTH];
		bit                     row_written [STORE_DEPTH];
		pix_t                   left_px;
		pix_t                   upper_left_px;
		int unsigned            column;
		bit                     first_row;
		logic [ROW_WIDTH_W-1:0] row_width;
		out_pixel_t             expected_pixels [$];
		int unsigned            mismatches;

		function new();
			left_px       = '0;
			upper_left_px = '0;
			column        = 0;
			first_row     = 1'b1;
			row_width     = ROW_WIDTH_RESET;
			mismatches    = 0;
		endfunction

		// the next pixel would read a row store entry never written
		function bit store_unwritten();
			return !first_row && !row_written[column];
		endfunction

		function bit [7:0] predict_byte(logic [2:0] ftype, bit [7:0] a, bit [7:0] b,
			bit [7:0] c);
			int p;
			int da;
			int db;
			int dc;
			case (ftype)
				FILT_SUB: return a;
				FILT_UP:  return b;
				FILT_AVG: return 8'((int'(a) + int'(b)) >> 1);
				FILT_PAETH: begin
					p  = int'(a) + int'(b) - int'(c);
					da = p - int'(a);
					db = p - int'(b);
					dc = p - int'(c);
					if (da < 0) da = -da;
					if (db < 0) db = -db;
					if (dc < 0) dc = -dc;
					if (da <= db && da <= dc) return a;
					if (db <= dc) return b;
					return c;
				end
				default: return 8'd0;
			endcase
		endfunction

		// note one accepted input pixel and queue its reconstruction
		function void take_pixel(logic [2:0] ftype, pix_t raw, bit start);
			int unsigned w;
			pix_t        a_px;
			pix_t        b_px;
			pix_t        c_px;
			pix_t        res;
			out_pixel_t  due;
			if (start) begin
				column        = 0;
				first_row     = 1'b1;
				left_px       = '0;
				upper_left_px = '0;
			end
			w = row_width;
			if (w == 0) w = 1;
			if (w > STORE_DEPTH) w = STORE_DEPTH;
			a_px = (column == 0) ? pix_t'('0) : left_px;
			b_px = first_row ? pix_t'('0) : row_store[column];
			c_px = (column == 0 || first_row) ? pix_t'('0) : upper_left_px;
			for (int ch = 0; ch < 4; ch++)
				res[ch] = raw[ch] + predict_byte(ftype, a_px[ch], b_px[ch], c_px[ch]);
			row_store[column]   = res;
			row_written[column] = 1'b1;
			upper_left_px       = b_px;
			left_px             = res;
			due.px              = res;
			if (column + 1 >= w) begin
				due.row_end   = 1'b1;
				column        = 0;
				first_row     = 1'b0;
				left_px       = '0;
				upper_left_px = '0;
			end else begin
				due.row_end = 1'b0;
				column      = column + 1;
			end
			expected_pixels.push_back(due);
		endfunction

		function void report_mismatch(string msg);
			$display("mismatch at %0t ns: %s", $realtime, msg);
			mismatches++;
		endfunction

		// compare one output transfer with the oldest prediction
		function void check_pixel(out_pixel_t got);
			out_pixel_t want;
			if (expected_pixels.size() == 0) begin
				report_mismatch("output pixel with none expected");
				return;
			end
			want = expected_pixels.pop_front();
			if (got.px[0] !== want.px[0])
				report_mismatch($sformatf("red %h, expected %h", got.px[0], want.px[0]));
			if (got.px[1] !== want.px[1])
				report_mismatch($sformatf("green %h, expected %h", got.px[1], want.px[1]));
			if (got.px[2] !== want.px[2])
				report_mismatch($sformatf("blue %h, expected %h", got.px[2], want.px[2]));
			if (got.px[3] !== want.px[3])
				report_mismatch($sformatf("alpha %h, expected %h", got.px[3], want.px[3]));
			if (got.row_end !== want.row_end)
				report_mismatch($sformatf("row_end %b, expected %b", got.row_end,
					want.row_end));
		endfunction
	endclass

	bit                     clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [ROW_WIDTH_W-1:0] cfg_wdata;
	bit                     no_idle;
	logic [2:0]             row_filter;

	unfilter_predictor unfilter = new();

	png_unf_in_if  pix_in_bus ();
	png_unf_out_if pix_out_bus ();

	png_scanline_unfilter_rgba8 dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.pix_in    (pix_in_bus),
		.pix_out   (pix_out_bus)
	);

	// 12 ns clock
	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// send one pixel after a random gap and note it once transferred
	task automatic send_pixel(logic [2:0] ftype, pix_t raw, bit start);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 4);
		if (unfilter.store_unwritten())
			start = 1'b1;
		repeat (gap) begin
			@(negedge clk);
			pix_in_bus.valid <= 1'b0;
		end
		@(negedge clk);
		pix_in_bus.valid       <= 1'b1;
		pix_in_bus.filter_type <= ftype;
		pix_in_bus.raw_red     <= raw[0];
		pix_in_bus.raw_green   <= raw[1];
		pix_in_bus.raw_blue    <= raw[2];
		pix_in_bus.raw_alpha   <= raw[3];
		pix_in_bus.image_start <= start;
		do
			@(posedge clk);
		while (pix_in_bus.ready !== 1'b1);
		unfilter.take_pixel(ftype, raw, start);
	endtask

	// random bytes, filter mostly held for the row, rare image start
	task automatic send_random_pixel();
		pix_t       raw;
		logic [2:0] ftype;
		bit         start;
		for (int ch = 0; ch < 4; ch++) begin
			case ($urandom_range(0, 7))
				0:       raw[ch] = 8'h00;
				1:       raw[ch] = 8'hFF;
				default: raw[ch] = 8'($urandom_range(0, 255));
			endcase
		end
		if (unfilter.column == 0)
			row_filter = 3'($urandom_range(0, 7));
		ftype = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : row_filter;
		start = ($urandom_range(0, 63) == 0);
		send_pixel(ftype, raw, start);
	endtask

	// drain the block, then write the row width
	task automatic write_width(logic [ROW_WIDTH_W-1:0] w);
		@(negedge clk);
		pix_in_bus.valid <= 1'b0;
		while (unfilter.expected_pixels.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= w;
		@(negedge clk);
		cfg_we <= 1'b0;
		unfilter.row_width = w;
	endtask

	// output side: random stall per pixel, check each transfer
	initial begin
		int stall;
		out_pixel_t got;
		pix_out_bus.ready = 1'b0;
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 4);
			repeat (stall) begin
				@(negedge clk);
				pix_out_bus.ready <= 1'b0;
			end
			@(negedge clk);
			pix_out_bus.ready <= 1'b1;
			do
				@(posedge clk);
			while (pix_out_bus.valid !== 1'b1);
			got.px[0]   = pix_out_bus.out_red;
			got.px[1]   = pix_out_bus.out_green;
			got.px[2]   = pix_out_bus.out_blue;
			got.px[3]   = pix_out_bus.out_alpha;
			got.row_end = pix_out_bus.row_end;
			unfilter.check_pixel(got);
		end
	end

	// stimulus
	initial begin
		int         sent;
		int         count;
		logic [10:0] w;
		arst_n                 = 1'b0;
		cfg_we                 = 1'b0;
		cfg_wdata              = '0;
		no_idle                = 1'b0;
		row_filter             = FILT_NONE;
		pix_in_bus.valid       = 1'b0;
		pix_in_bus.filter_type = FILT_NONE;
		pix_in_bus.raw_red     = '0;
		pix_in_bus.raw_green   = '0;
		pix_in_bus.raw_blue    = '0;
		pix_in_bus.raw_alpha   = '0;
		pix_in_bus.image_start = 1'b0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// directed: four-pixel rows covering every filter code and byte extremes
		write_width(11'd4);
		send_pixel(FILT_NONE,   32'h7F80FF00, 1'b1);
		send_pixel(FILT_SUB,    32'h8001FFFF, 1'b0);
		send_pixel(FILT_SUB,    32'hFFFF0001, 1'b0);
		send_pixel(FILT_SPARE5, 32'h78563412, 1'b0);
		send_pixel(FILT_UP,     32'hFF00FF01, 1'b0);
		send_pixel(FILT_AVG,    32'h00FF00FF, 1'b0);
		send_pixel(FILT_PAETH,  32'hFFFFFFFF, 1'b0);
		send_pixel(FILT_SPARE6, 32'h00000000, 1'b0);
		send_pixel(FILT_PAETH,  32'h00000000, 1'b0);
		send_pixel(FILT_AVG,    32'hFFFFFFFF, 1'b0);
		send_pixel(FILT_SPARE7, 32'hA5A55A5A, 1'b0);
		send_pixel(FILT_SUB,    32'h01010101, 1'b0);
		send_pixel(FILT_PAETH,  32'hFF00FF00, 1'b0);
		send_pixel(FILT_PAETH,  32'h0080FF7F, 1'b0);
		send_pixel(FILT_UP,     32'h00000000, 1'b0);
		send_pixel(FILT_NONE,   32'hFFFFFFFF, 1'b0);
		// image start in mid-row
		send_pixel(FILT_SUB,    32'h00000000, 1'b0);
		send_pixel(FILT_UP,     32'h44332211, 1'b1);
		send_pixel(FILT_PAETH,  32'h10203040, 1'b0);

		// zero width acts as one pixel per row
		write_width(11'd0);
		send_pixel(FILT_UP,    32'h01020304, 1'b1);
		send_pixel(FILT_UP,    32'hFFFFFFFF, 1'b0);
		send_pixel(FILT_PAETH, 32'h80808080, 1'b0);

		// oversize width acts as a full-length row
		write_width(11'd2047);
		repeat (STORE_DEPTH + 6) send_random_pixel();

		// narrowing below the current column ends the row at once
		write_width(11'd3);
		send_pixel(FILT_UP,  32'h0F0F0F0F, 1'b0);
		send_pixel(FILT_SUB, 32'hF0F0F0F0, 1'b0);

		// random phases, mostly narrow rows so the row above is in play
		sent = 0;
		while (sent < RANDOM_PIXELS) begin
			case ($urandom_range(0, 9))
				0:       w = 11'd0;
				1:       w = 11'($urandom_range(17, 64));
				2:       w = 11'($urandom_range(1000, 2047));
				3:       w = 11'd1;
				default: w = 11'($urandom_range(2, 16));
			endcase
			count   = $urandom_range(5, 60);
			no_idle = ($urandom_range(0, 3) == 0);
			write_width(w);
			repeat (count) send_random_pixel();
			sent += count;
		end

		@(negedge clk);
		pix_in_bus.valid <= 1'b0;
		while (unfilter.expected_pixels.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (unfilter.mismatches == 0)
			$display("png_scanline_unfilter_rgba8 test passed");
		else
			$display("png_scanline_unfilter_rgba8 test failed");
		$finish;
	end

	// watchdog
	initial begin
		#5000000;
		$display("png_scanline_unfilter_rgba8 test failed");
		$finish;
	end

endmodule : tb_top
